// ===== hdl/bldws_pkg.sv =====
// shared types, codes and the control store of the list sequencer
package bldws_pkg;

  // stream widths: fields packed from bit 0, padded to whole bytes
  localparam int unsigned ValueW     = 32;
  localparam int unsigned ActionW    = 3;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned InTdataW   = 40;
  localparam int unsigned OutTdataW  = 40;
  localparam int unsigned StepW      = 5;

  typedef logic [StepW-1:0] step_t;

  // action codes of an input transaction
  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_SEARCH     = 3'd5
  } action_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // control word fields
  typedef enum logic [1:0] {RD_NONE, RD_OFF, RD_LAST} rd_sel_e;
  typedef enum logic [1:0] {WR_NONE, WR_FRONT, WR_BACK, WR_SHIFT} wr_sel_e;
  typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC} cnt_op_e;
  typedef enum logic [1:0] {FR_KEEP, FR_DEC, FR_INC} fr_op_e;
  typedef enum logic [2:0] {RES_NONE, RES_FOUND, RES_POP, RES_FULL, RES_EMPTY} res_op_e;
  typedef enum logic [2:0] {
    COND_NONE, COND_ALWAYS, COND_FULL, COND_EMPTY, COND_MATCH, COND_NOPEND
  } cond_e;
  typedef enum logic [1:0] {NXT_INC, NXT_HOLD, NXT_HOLD_END} nxt_e;

  typedef struct packed {
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    cnt_op_e cnt_op;
    fr_op_e  fr_op;
    res_op_e res_op;
    cond_e   cond;
    nxt_e    nxt;
    step_t   target;
    logic    last;
  } ucw_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic nopend;
    logic scan_end;
  } flags_t;

  // result of one transaction
  typedef struct packed {
    logic [ValueW-1:0]  popped_value;
    logic               found;
    logic [StatusW-1:0] status;
  } res_t;

  // program step addresses
  localparam step_t S_PF0    = 5'd0;
  localparam step_t S_PF1    = 5'd1;
  localparam step_t S_PB0    = 5'd2;
  localparam step_t S_PB1    = 5'd3;
  localparam step_t S_POPF0  = 5'd4;
  localparam step_t S_POPF1  = 5'd5;
  localparam step_t S_POPB0  = 5'd6;
  localparam step_t S_POPB1  = 5'd7;
  localparam step_t S_FULL   = 5'd8;
  localparam step_t S_EMPTY  = 5'd9;
  localparam step_t S_REM0   = 5'd10;
  localparam step_t S_REM_NF = 5'd11;
  localparam step_t S_REM1   = 5'd12;
  localparam step_t S_REM2   = 5'd13;
  localparam step_t S_FOUND  = 5'd14;
  localparam step_t S_SRCH0  = 5'd15;
  localparam step_t S_END    = 5'd16;

  localparam ucw_t UCW_NOP = '{RD_NONE, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                               COND_NONE, NXT_INC, S_END, 1'b0};

  // build one control word
  function automatic ucw_t uw(rd_sel_e rd, wr_sel_e wr, cnt_op_e cnt, fr_op_e fr,
                              res_op_e res, cond_e cond, nxt_e nxt, step_t tgt,
                              logic last);
    ucw_t w;
    w.rd_sel = rd;
    w.wr_sel = wr;
    w.cnt_op = cnt;
    w.fr_op  = fr;
    w.res_op = res;
    w.cond   = cond;
    w.nxt    = nxt;
    w.target = tgt;
    w.last   = last;
    return w;
  endfunction

  // control store
  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    case (s)
      // push front: check full, write below the front
      S_PF0:    w = uw(RD_NONE, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_FULL, NXT_INC, S_FULL, 1'b0);
      S_PF1:    w = uw(RD_NONE, WR_FRONT, CNT_INC, FR_DEC, RES_NONE,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
      // push back: check full, write past the back
      S_PB0:    w = uw(RD_NONE, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_FULL, NXT_INC, S_FULL, 1'b0);
      S_PB1:    w = uw(RD_NONE, WR_BACK, CNT_INC, FR_KEEP, RES_NONE,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
      // pop front: read front entry, advance front
      S_POPF0:  w = uw(RD_OFF, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_EMPTY, NXT_INC, S_EMPTY, 1'b0);
      S_POPF1:  w = uw(RD_NONE, WR_NONE, CNT_DEC, FR_INC, RES_POP,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
      // pop back: read last entry
      S_POPB0:  w = uw(RD_LAST, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_EMPTY, NXT_INC, S_EMPTY, 1'b0);
      S_POPB1:  w = uw(RD_NONE, WR_NONE, CNT_DEC, FR_KEEP, RES_POP,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
      S_FULL:   w = uw(RD_NONE, WR_NONE, CNT_KEEP, FR_KEEP, RES_FULL,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
      S_EMPTY:  w = uw(RD_NONE, WR_NONE, CNT_KEEP, FR_KEEP, RES_EMPTY,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
      // remove: scan for a match, then pull the tail down one place
      S_REM0:   w = uw(RD_OFF, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_MATCH, NXT_HOLD_END, S_REM1, 1'b0);
      S_REM_NF: w = uw(RD_NONE, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
      S_REM1:   w = uw(RD_OFF, WR_SHIFT, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_NOPEND, NXT_HOLD, S_REM2, 1'b0);
      S_REM2:   w = uw(RD_NONE, WR_NONE, CNT_DEC, FR_KEEP, RES_FOUND,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
      S_FOUND:  w = uw(RD_NONE, WR_NONE, CNT_KEEP, FR_KEEP, RES_FOUND,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
      // search: scan, fall into the end step when exhausted
      S_SRCH0:  w = uw(RD_OFF, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_MATCH, NXT_HOLD_END, S_FOUND, 1'b0);
      S_END:    w = uw(RD_NONE, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_NONE, NXT_INC, S_END, 1'b1);
      default:  w = uw(RD_NONE, WR_NONE, CNT_KEEP, FR_KEEP, RES_NONE,
                       COND_ALWAYS, NXT_INC, S_END, 1'b0);
    endcase
    return w;
  endfunction

  // entry step of each action
  function automatic step_t dispatch(logic [ActionW-1:0] act);
    step_t s;
    case (act)
      ACT_PUSH_FRONT: s = S_PF0;
      ACT_PUSH_BACK:  s = S_PB0;
      ACT_POP_FRONT:  s = S_POPF0;
      ACT_POP_BACK:   s = S_POPB0;
      ACT_REMOVE:     s = S_REM0;
      ACT_SEARCH:     s = S_SRCH0;
      default:        s = S_END;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/bldws_seq.sv =====
// step counter and control store of the list sequencer
module bldws_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bldws_pkg::ActionW-1:0] action_i,
  input  bldws_pkg::flags_t             flags_i,
  input  logic                          out_free_i,
  output bldws_pkg::ucw_t               ctrl_o,
  output logic                          busy_o,
  output logic                          done_o
);

  bldws_pkg::step_t step_q, step_d;
  logic             busy_q, busy_d;
  bldws_pkg::ucw_t  ucw;
  logic             cond_hit;

  // fetch the control word of the current step
  assign ucw    = bldws_pkg::ucode(step_q);
  assign ctrl_o = busy_q ? ucw : bldws_pkg::UCW_NOP;
  assign busy_o = busy_q;
  assign done_o = busy_q && ucw.last && out_free_i;

  // jump condition
  always_comb begin
    case (ucw.cond)
      bldws_pkg::COND_ALWAYS: cond_hit = 1'b1;
      bldws_pkg::COND_FULL:   cond_hit = flags_i.full;
      bldws_pkg::COND_EMPTY:  cond_hit = flags_i.empty;
      bldws_pkg::COND_MATCH:  cond_hit = flags_i.match;
      bldws_pkg::COND_NOPEND: cond_hit = flags_i.nopend;
      default:                cond_hit = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      step_d = bldws_pkg::dispatch(action_i);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ucw.last) begin
        if (out_free_i) begin
          busy_d = 1'b0;
        end
      end else if (cond_hit) begin
        step_d = ucw.target;
      end else begin
        case (ucw.nxt)
          bldws_pkg::NXT_HOLD:     step_d = step_q;
          bldws_pkg::NXT_HOLD_END: step_d = flags_i.scan_end ? step_q + 1'b1 : step_q;
          default:                 step_d = step_q + 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= bldws_pkg::S_END;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== hdl/bldws_dp.sv =====
// list datapath: circular entry store, front and count, scan pipeline, results
module bldws_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bldws_pkg::ValueW-1:0] value_i,
  input  bldws_pkg::ucw_t              ctrl_i,
  output bldws_pkg::flags_t            flags_o,
  output bldws_pkg::res_t              res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;

  logic [bldws_pkg::ValueW-1:0] mem_q [CAPACITY];

  logic [AW-1:0]                 front_q, front_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [CW-1:0]                 rd_off_q, rd_off_d;
  logic                          pv_q, pv_d;
  logic [bldws_pkg::ValueW-1:0]  val_q;
  logic [bldws_pkg::ValueW-1:0]  rdata_q;
  logic [bldws_pkg::ValueW-1:0]  popped_q;
  logic                          found_q;
  logic [bldws_pkg::StatusW-1:0] status_q;

  logic [AW-1:0]                 front_dec, front_inc;
  logic [CW-1:0]                 last_off;
  logic                          rd_en, wr_en;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic [bldws_pkg::ValueW-1:0]  wr_data;

  // store index of a list offset, offset at most CAPACITY
  function automatic logic [AW-1:0] slot(logic [AW-1:0] fr, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(fr) + SW'(off);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  // front neighbors with wrap
  assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(CAPACITY - 1)) ? '0 : front_q + AW'(1);
  assign last_off  = (count_q == '0) ? '0 : count_q - CW'(1);

  // flags for the sequencer
  assign flags_o.full     = (count_q == CW'(CAPACITY));
  assign flags_o.empty    = (count_q == '0);
  assign flags_o.match    = pv_q && (rdata_q == val_q);
  assign flags_o.nopend   = !pv_q;
  assign flags_o.scan_end = (rd_off_q >= count_q);

  // read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot(front_q, rd_off_q);
    case (ctrl_i.rd_sel)
      bldws_pkg::RD_OFF:  rd_en = (rd_off_q < count_q);
      bldws_pkg::RD_LAST: begin
        rd_en   = 1'b1;
        rd_addr = slot(front_q, last_off);
      end
      default:            rd_en = 1'b0;
    endcase
  end

  // write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = front_dec;
    wr_data = val_q;
    case (ctrl_i.wr_sel)
      bldws_pkg::WR_FRONT: wr_en = 1'b1;
      bldws_pkg::WR_BACK: begin
        wr_en   = 1'b1;
        wr_addr = slot(front_q, count_q);
      end
      bldws_pkg::WR_SHIFT: begin
        // pending read of offset k lands at offset k-1
        wr_en   = pv_q;
        wr_addr = slot(front_q, rd_off_q - CW'(2));
        wr_data = rdata_q;
      end
      default:             wr_en = 1'b0;
    endcase
  end

  // entry store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // list pointers and scan state
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    rd_off_d = rd_off_q;
    pv_d     = 1'b0;
    case (ctrl_i.fr_op)
      bldws_pkg::FR_DEC: front_d = front_dec;
      bldws_pkg::FR_INC: front_d = front_inc;
      default:           front_d = front_q;
    endcase
    case (ctrl_i.cnt_op)
      bldws_pkg::CNT_INC: count_d = count_q + CW'(1);
      bldws_pkg::CNT_DEC: count_d = count_q - CW'(1);
      default:            count_d = count_q;
    endcase
    if (ctrl_i.rd_sel == bldws_pkg::RD_OFF && rd_en) begin
      rd_off_d = rd_off_q + CW'(1);
      pv_d     = 1'b1;
    end
    if (start_i) begin
      rd_off_d = '0;
      pv_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      rd_off_q <= '0;
      pv_q     <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      rd_off_q <= rd_off_d;
      pv_q     <= pv_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q    <= value_i;
      popped_q <= '0;
      found_q  <= 1'b0;
      status_q <= bldws_pkg::ST_OK;
    end else begin
      case (ctrl_i.res_op)
        bldws_pkg::RES_FOUND: found_q  <= 1'b1;
        bldws_pkg::RES_POP:   popped_q <= rdata_q;
        bldws_pkg::RES_FULL:  status_q <= bldws_pkg::ST_FULL;
        bldws_pkg::RES_EMPTY: status_q <= bldws_pkg::ST_EMPTY;
        default:              found_q  <= found_q;
      endcase
    end
  end

  assign res_o.popped_value = popped_q;
  assign res_o.found        = found_q;
  assign res_o.status       = status_q;

endmodule

// ===== hdl/bounded_list_deque_with_search.sv =====
// top level of the bounded list deque with search
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  s_axis  | in  | s_axis_tvalid/_tready  | tdata: action[2:0], value[34:3]
//  m_axis  | out | m_axis_tvalid/_tready  | tdata: popped_value[31:0],
//          |     |                        |        found[32], status[34:33]
//
// one transaction at a time; the accept cycle picks the entry step of the microprogram
// search and remove run a scan loop that reads one stored entry per cycle
// from the store port
// the result waits in an output register; a new transaction is taken while it waits
// reset empties the list; store contents are not cleared
module bounded_list_deque_with_search #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // action[2:0], value[34:3], zero pad[39:35]
  input  logic [bldws_pkg::InTdataW-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // popped_value[31:0], found[32], status[34:33], zero pad[39:35]
  output logic [bldws_pkg::OutTdataW-1:0]   m_axis_tdata
);

  localparam int unsigned ResW = bldws_pkg::ValueW + 1 + bldws_pkg::StatusW;

  logic              start;
  logic              busy;
  logic              done;
  logic              out_free;
  bldws_pkg::ucw_t   ctrl;
  bldws_pkg::flags_t flags;
  bldws_pkg::res_t   res;
  logic              out_valid_q;
  bldws_pkg::res_t   out_res_q;

  // input transaction
  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  bldws_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .action_i   (s_axis_tdata[bldws_pkg::ActionW-1:0]),
    .flags_i    (flags),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .done_o     (done)
  );

  bldws_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (s_axis_tdata[bldws_pkg::ActionW +: bldws_pkg::ValueW]),
    .ctrl_i  (ctrl),
    .flags_o (flags),
    .res_o   (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(bldws_pkg::OutTdataW - ResW)'(0), out_res_q.status,
                          out_res_q.found, out_res_q.popped_value};

  // an accepted transaction keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !s_axis_tready)
    else $error("input ready right after an accepted transaction");

  // a result is only loaded when the output register can take it
  a_done_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!out_valid_q || m_axis_tready))
    else $error("result overwrote a pending output transaction");

  // a found result never carries a popped value or an error status
  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.found) |->
      (out_res_q.popped_value == '0 && out_res_q.status == bldws_pkg::ST_OK))
    else $error("found result with popped value or error status");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the bounded list deque with search
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned HOLD_AT_ITEM = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // action codes the block ignores
  localparam logic [bldws_pkg::ActionW-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [bldws_pkg::ActionW-1:0] ACT_SPARE7 = 3'd7;

  // one row of directed stimulus; res is only used where known is set
  typedef struct packed {
    logic [bldws_pkg::ActionW-1:0] act;
    logic [bldws_pkg::ValueW-1:0]  value;
    logic [4:0]                    reps;
    logic                          known;
    bldws_pkg::res_t               res;
  } vector_row_t;

  localparam int unsigned NUM_ROWS = 25;
  localparam vector_row_t VECTOR_TABLE [NUM_ROWS] = '{
    // empty list corner cases and ignored codes
    '{bldws_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_EMPTY}},
    '{bldws_pkg::ACT_POP_BACK,   32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_EMPTY}},
    '{bldws_pkg::ACT_SEARCH,     32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_REMOVE,     32'h8000_0000, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{ACT_SPARE6,                32'h1234_5678, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{ACT_SPARE7,                32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    // value extremes at both ends, front wraps below slot zero
    '{bldws_pkg::ACT_PUSH_BACK,  32'h7FFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_PUSH_FRONT, 32'h8000_0000, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_PUSH_BACK,  32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_SEARCH,     32'h7FFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 1'b1, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_SEARCH,     32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1,
      '{32'h8000_0000, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_POP_BACK,   32'h0000_0000, 5'd1,  1'b1,
      '{32'hFFFF_FFFF, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_REMOVE,     32'h7FFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 1'b1, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_EMPTY}},
    // fill to capacity, then push on a full list from both ends
    '{bldws_pkg::ACT_PUSH_FRONT, 32'h0000_0100, 5'd16, 1'b0,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_PUSH_BACK,  32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_FULL}},
    '{bldws_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 1'b0, bldws_pkg::ST_FULL}},
    // remove from the middle and the end, search at the front
    '{bldws_pkg::ACT_REMOVE,     32'h0000_0107, 5'd1,  1'b0,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_SEARCH,     32'h0000_010F, 5'd1,  1'b0,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_REMOVE,     32'h0000_0100, 5'd1,  1'b0,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_PUSH_BACK,  32'h0000_0055, 5'd1,  1'b0,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_POP_BACK,   32'h0000_0000, 5'd1,  1'b0,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_SEARCH,     32'h0000_0107, 5'd1,  1'b0,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}},
    '{bldws_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0,
      '{32'h0, 1'b0, bldws_pkg::ST_OK}}
  };

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [bldws_pkg::InTdataW-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bldws_pkg::OutTdataW-1:0] m_axis_tdata;

  // typed-in result that travels with the offered transaction
  logic            offer_known = 1'b0;
  bldws_pkg::res_t offer_res   = '0;

  // shadow of the list: store, occupancy and front slot
  logic [bldws_pkg::ValueW-1:0] shadow_store [CAPACITY];
  int unsigned                  shadow_count = 0;
  int unsigned                  shadow_front = 0;

  bldws_pkg::res_t pending_results [$];
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;

  // sender-side bookkeeping for shaping the stimulus
  logic [bldws_pkg::ValueW-1:0] recent_values [8] = '{default: '0};
  int unsigned                  fill_guess = 0;
  bit                           send_burst = 1'b0;
  bit                           hold_req   = 1'b0;

  always #6 clk_i = ~clk_i;

  bounded_list_deque_with_search #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic int unsigned shadow_slot(int unsigned offset);
    return (shadow_front + offset) % CAPACITY;
  endfunction

  // apply one action to the shadow list and return the result it gives
  function automatic bldws_pkg::res_t deque_apply(logic [bldws_pkg::ActionW-1:0] act,
                                                  logic [bldws_pkg::ValueW-1:0] v);
    bldws_pkg::res_t r;
    int              hit;
    int unsigned     i;
    r   = '0;
    hit = -1;
    for (i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_store[shadow_slot(i)] == v) hit = i;
    end
    case (act)
      bldws_pkg::ACT_PUSH_FRONT, bldws_pkg::ACT_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          r.status = bldws_pkg::ST_FULL;
        end else if (act == bldws_pkg::ACT_PUSH_FRONT) begin
          shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
          shadow_store[shadow_front] = v;
          shadow_count++;
        end else begin
          shadow_store[shadow_slot(shadow_count)] = v;
          shadow_count++;
        end
      end
      bldws_pkg::ACT_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = bldws_pkg::ST_EMPTY;
        end else begin
          r.popped_value = shadow_store[shadow_front];
          shadow_front = shadow_slot(1);
          shadow_count--;
        end
      end
      bldws_pkg::ACT_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = bldws_pkg::ST_EMPTY;
        end else begin
          r.popped_value = shadow_store[shadow_slot(shadow_count - 1)];
          shadow_count--;
        end
      end
      bldws_pkg::ACT_REMOVE: begin
        if (hit >= 0) begin
          // close the gap so the tail keeps its order
          for (i = hit; i + 1 < shadow_count; i++) begin
            shadow_store[shadow_slot(i)] = shadow_store[shadow_slot(i + 1)];
          end
          shadow_count--;
          r.found = 1'b1;
        end
      end
      bldws_pkg::ACT_SEARCH: r.found = (hit >= 0);
      default: ;
    endcase
    return r;
  endfunction

  // offer one transaction after a random gap and wait until it is taken
  task automatic offer(input logic [bldws_pkg::ActionW-1:0] act,
                       input logic [bldws_pkg::ValueW-1:0] v,
                       input logic known, input bldws_pkg::res_t res);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(bldws_pkg::InTdataW - bldws_pkg::ActionW - bldws_pkg::ValueW){1'b0}},
                      v, act};
    offer_known   <= known;
    offer_res     <= res;
    case (act)
      bldws_pkg::ACT_PUSH_FRONT, bldws_pkg::ACT_PUSH_BACK: begin
        recent_values[$urandom_range(0, 7)] = v;
        if (fill_guess < CAPACITY) fill_guess++;
      end
      bldws_pkg::ACT_POP_FRONT, bldws_pkg::ACT_POP_BACK, bldws_pkg::ACT_REMOVE:
        if (fill_guess > 0) fill_guess--;
      default: ;
    endcase
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // predict on accepted inputs, compare on accepted outputs
  always @(posedge clk_i) begin : result_check
    bldws_pkg::res_t               want;
    logic [bldws_pkg::ValueW-1:0]  got_pop;
    logic                          got_found;
    logic [bldws_pkg::StatusW-1:0] got_status;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_pop    = m_axis_tdata[bldws_pkg::ValueW-1:0];
        got_found  = m_axis_tdata[bldws_pkg::ValueW];
        got_status = m_axis_tdata[bldws_pkg::ValueW+bldws_pkg::StatusW:bldws_pkg::ValueW+1];
        if (pending_results.size() == 0) begin
          $error("result transaction with none pending: tdata %h", m_axis_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got_pop !== want.popped_value) begin
            $error("popped_value: expected %h, got %h", want.popped_value, got_pop);
            error_count++;
          end
          if (got_found !== want.found) begin
            $error("found: expected %b, got %b", want.found, got_found);
            error_count++;
          end
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = deque_apply(s_axis_tdata[bldws_pkg::ActionW-1:0],
                           s_axis_tdata[bldws_pkg::ActionW+bldws_pkg::ValueW-1:
                                        bldws_pkg::ActionW]);
        pending_results.push_back(offer_known ? offer_res : want);
      end
    end
  end

  // result sink with random stalls and one long hold-off
  initial begin : result_sink
    int unsigned stall;
    bit          burst;
    bit          hold_done;
    burst     = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      stall = burst ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // cycle counter guarding against a hang
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results pending", cycle_count,
           pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // reset, directed table, random traffic, drain and verdict
  initial begin : stimulus
    int unsigned                   row;
    int unsigned                   rep;
    int unsigned                   items_sent;
    int unsigned                   pick;
    int unsigned                   kind;
    bit                            filling;
    logic [bldws_pkg::ActionW-1:0] act;
    logic [bldws_pkg::ValueW-1:0]  val;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < NUM_ROWS; row++) begin
      for (rep = 0; rep < VECTOR_TABLE[row].reps; rep++) begin
        offer(VECTOR_TABLE[row].act, VECTOR_TABLE[row].value + rep,
              VECTOR_TABLE[row].known, VECTOR_TABLE[row].res);
      end
    end

    // alternate fill and drain phases so full and empty recur
    items_sent = 0;
    filling    = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      if (fill_guess >= CAPACITY) filling = 1'b0;
      else if (fill_guess == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 45 : 15)) begin
        act = $urandom_range(0, 1) ? bldws_pkg::ACT_PUSH_BACK : bldws_pkg::ACT_PUSH_FRONT;
      end else if (pick < (filling ? 60 : 55)) begin
        act = $urandom_range(0, 1) ? bldws_pkg::ACT_POP_BACK : bldws_pkg::ACT_POP_FRONT;
      end else if (pick < (filling ? 78 : 72)) begin
        act = bldws_pkg::ACT_REMOVE;
      end else if (pick < 97) begin
        act = bldws_pkg::ACT_SEARCH;
      end else begin
        act = $urandom_range(0, 1) ? ACT_SPARE7 : ACT_SPARE6;
      end
      // mostly recently pushed values for remove and search, duplicates for pushes
      kind = $urandom_range(0, 9);
      if ((act == bldws_pkg::ACT_REMOVE || act == bldws_pkg::ACT_SEARCH) && kind < 7) begin
        val = recent_values[$urandom_range(0, 7)];
      end else if (kind < 5) begin
        val = $urandom_range(0, 31) - 16;
      end else if (kind < 9) begin
        val = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0:       val = 32'h0000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'h8000_0000;
          default: val = 32'hFFFF_FFFF;
        endcase
      end
      if (act <= bldws_pkg::ACT_SEARCH) items_sent++;
      if (items_sent == HOLD_AT_ITEM) hold_req = 1'b1;
      offer(act, val, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
